>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/fpd_pkg.sv
// Shared types, widths and the CORDIC arctangent table of the peak detector
package fpd_pkg;

  localparam int PART_W       = 27;
  localparam int TW_W         = 19;
  localparam int MAG_W        = 54;
  localparam int RATE_W       = 24;
  localparam int PEAK_W       = 10;
  localparam int FREQ_W       = 23;
  localparam int SIZE_W       = 11;
  localparam int CORDIC_STEPS = 30;
  localparam logic [RATE_W-1:0] RATE_RESET = 24'd48000;

  typedef logic signed [PART_W-1:0] part_t;

  typedef struct packed {
    part_t re;
    part_t im;
  } cplx_t;

  typedef struct packed {
    logic signed [TW_W-1:0] wr;
    logic signed [TW_W-1:0] wi;
  } twid_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/fpd_cordic.sv
// Iterative rotation-mode CORDIC producing one Q1.17 twiddle, one step per cycle
module fpd_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   phase,
  output logic          done,
  output fpd_pkg::twid_t tw
);
  import fpd_pkg::*;

  localparam logic signed [33:0] START_GAIN = 34'sd652032874;
  localparam logic [4:0]         LAST_STEP  = 5'(CORDIC_STEPS - 1);

  logic                run_r;
  logic                done_r;
  logic [4:0]          step_r;
  logic [1:0]          quad_r;
  logic signed [33:0]  cx_r, cy_r, z_r;
  logic signed [33:0]  dx, dy, at;
  logic signed [TW_W-1:0] c, s, cf, sf;

  function automatic logic signed [TW_W-1:0] to_q17(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd4096) >>> 13;
    if (r < 0) begin
      r = '0;
    end else if (r > 34'sd131072) begin
      r = 34'sd131072;
    end
    return TW_W'(r);
  endfunction

  assign dx = cy_r >>> step_r;
  assign dy = cx_r >>> step_r;
  assign at = 34'(atan_turn(step_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx_r   <= START_GAIN;
      cy_r   <= '0;
      z_r    <= 34'({4'b0, phase[29:0]});
      quad_r <= phase[31:30];
    end else if (run_r) begin
      if (z_r >= 0) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + at;
      end
    end
  end

  assign c = to_q17(cx_r);
  assign s = to_q17(cy_r);

  // quadrant symmetry
  always_comb begin
    case (quad_r)
      2'd0:    begin cf = c;  sf = s;  end
      2'd1:    begin cf = -s; sf = c;  end
      2'd2:    begin cf = -c; sf = -s; end
      default: begin cf = s;  sf = -c; end
    endcase
  end

  assign tw.wr = cf;
  assign tw.wi = -sf;
  assign done  = done_r;

endmodule

>>> src/fpd_butterfly.sv
// Radix-2 butterfly datapath, three register stages, saturating 27-bit parts
module fpd_butterfly (
  input  logic           clk,
  input  fpd_pkg::cplx_t a,
  input  fpd_pkg::cplx_t b,
  input  fpd_pkg::twid_t w,
  output fpd_pkg::cplx_t x,
  output fpd_pkg::cplx_t y
);
  import fpd_pkg::*;

  localparam int PROD_W = TW_W + PART_W;
  localparam int ROT_W  = 29;
  localparam int SUM_W  = 30;

  logic signed [PROD_W-1:0] m_rr_r, m_ii_r, m_ri_r, m_ir_r;
  logic signed [PROD_W:0]   d_re, d_im;
  logic signed [ROT_W-1:0]  pr_r, pi_r;
  logic signed [SUM_W-1:0]  s_re, s_im, t_re, t_im;
  cplx_t                    a1_r, a2_r, x_r, y_r;

  function automatic part_t sat27(input logic signed [SUM_W-1:0] v);
    part_t r;
    if (v > SUM_W'(67108863)) begin
      r = 27'sd67108863;
    end else if (v < -SUM_W'(67108864)) begin
      r = -27'sd67108864;
    end else begin
      r = PART_W'(v);
    end
    return r;
  endfunction

  // stage 1: products
  always_ff @(posedge clk) begin
    m_rr_r <= PROD_W'(w.wr) * PROD_W'(b.re);
    m_ii_r <= PROD_W'(w.wi) * PROD_W'(b.im);
    m_ri_r <= PROD_W'(w.wr) * PROD_W'(b.im);
    m_ir_r <= PROD_W'(w.wi) * PROD_W'(b.re);
    a1_r   <= a;
  end

  assign d_re = (PROD_W+1)'(m_rr_r) - (PROD_W+1)'(m_ii_r) + (PROD_W+1)'(65536);
  assign d_im = (PROD_W+1)'(m_ri_r) + (PROD_W+1)'(m_ir_r) + (PROD_W+1)'(65536);

  // stage 2: round to integer
  always_ff @(posedge clk) begin
    pr_r <= ROT_W'(d_re >>> 17);
    pi_r <= ROT_W'(d_im >>> 17);
    a2_r <= a1_r;
  end

  assign s_re = SUM_W'(a2_r.re) + SUM_W'(pr_r);
  assign s_im = SUM_W'(a2_r.im) + SUM_W'(pi_r);
  assign t_re = SUM_W'(a2_r.re) - SUM_W'(pr_r);
  assign t_im = SUM_W'(a2_r.im) - SUM_W'(pi_r);

  // stage 3: sum, difference, saturate
  always_ff @(posedge clk) begin
    x_r.re <= sat27(s_re);
    x_r.im <= sat27(s_im);
    y_r.re <= sat27(t_re);
    y_r.im <= sat27(t_im);
  end

  assign x = x_r;
  assign y = y_r;

endmodule

>>> src/fpd_mag.sv
// Squared magnitude of one bin, two register stages
module fpd_mag (
  input  logic                      clk,
  input  fpd_pkg::cplx_t            d,
  output logic [fpd_pkg::MAG_W-1:0] mag
);
  import fpd_pkg::*;

  logic signed [MAG_W-1:0] rr_r, ii_r;
  logic [MAG_W-1:0]        mag_r;

  always_ff @(posedge clk) begin
    rr_r  <= MAG_W'(d.re) * MAG_W'(d.re);
    ii_r  <= MAG_W'(d.im) * MAG_W'(d.im);
    mag_r <= MAG_W'(rr_r) + MAG_W'(ii_r);
  end

  assign mag = mag_r;

endmodule

>>> src/fft_peak_frequency_detector_top.sv
// Top level: sample store, FFT sequencer, peak scan and result register
// After reset a twiddle table of 2^(clog2(MAX_POINTS)-1) entries is built by the CORDIC.
// Samples then enter at one per cycle while loading; a last sample starts the transform.
// Then come zero padding, bit-reversal swaps, (n/2)log2 n butterflies, a scan of bins
// 0..n/2 and the frequency product, after which the result is registered.
// Synchronous active-low reset clears control and fill counters; rate_r resets to 48000.
`include "assert_macros.svh"
module fft_peak_frequency_detector_top #(
  parameter int MAX_POINTS  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpd_pkg::PEAK_W-1:0]    out_peak_bin,
  output logic [fpd_pkg::FREQ_W-1:0]    out_frequency_hz,
  output logic [fpd_pkg::SIZE_W-1:0]    out_fft_size,
  output logic                          out_truncated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpd_pkg::RATE_W-1:0]    cfg_sample_rate_hz
);
  import fpd_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int DEPTH = 1 << AW;
  localparam int CNTW  = AW + 1;
  localparam int LGW   = $clog2(AW + 1);
  localparam int TWD   = DEPTH / 2;
  localparam int TWAW  = (AW > 1) ? AW - 1 : 1;
  localparam int PRODW = AW + RATE_W;

  typedef enum logic [15:0] {
    S_TWSTART = 16'b0000_0000_0000_0001,
    S_TWWAIT  = 16'b0000_0000_0000_0010,
    S_LOAD    = 16'b0000_0000_0000_0100,
    S_PAD     = 16'b0000_0000_0000_1000,
    S_PERM    = 16'b0000_0000_0001_0000,
    S_PSW1    = 16'b0000_0000_0010_0000,
    S_PSW2    = 16'b0000_0000_0100_0000,
    S_BFRD    = 16'b0000_0000_1000_0000,
    S_BFWAIT  = 16'b0000_0001_0000_0000,
    S_BFWT    = 16'b0000_0010_0000_0000,
    S_BFWB    = 16'b0000_0100_0000_0000,
    S_SCRD    = 16'b0000_1000_0000_0000,
    S_SCWAIT  = 16'b0001_0000_0000_0000,
    S_SCCMP   = 16'b0010_0000_0000_0000,
    S_FREQ    = 16'b0100_0000_0000_0000,
    S_DONE    = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // block bookkeeping
  logic [RATE_W-1:0] rate_r;
  logic [CNTW-1:0]   cnt_r, size_r, ptr_r, cnt_inc;
  logic [LGW-1:0]    lg_r, sl_r;
  logic              ovf_r;
  logic [AW-1:0]     j_r, best_r;
  logic [1:0]        wcnt_r;
  logic [TWAW-1:0]   k_r;
  logic [MAG_W-1:0]  bmag_r, mag;
  logic [PRODW-1:0]  prod_r;
  logic              accept, room;

  // result register
  logic              out_valid_r;
  logic [PEAK_W-1:0] out_peak_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic [SIZE_W-1:0] out_size_r;
  logic              out_trunc_r;

  // sample / spectrum store: one write port, two registered read ports
  cplx_t           mem [DEPTH];
  cplx_t           rd_a_r, rd_b_r, wdata;
  logic            we, rd_en;
  logic [AW-1:0]   waddr, ra, rb;

  // twiddle table for the largest transform
  twid_t           twm [TWD];
  twid_t           tw_rd_r, cordic_tw;
  logic            tw_we, tw_re, cordic_start, cordic_done;
  logic [TWAW-1:0] tw_k;

  // butterfly addressing
  logic [AW-1:0]   mid_w, low_w, q_w, top_w, bot_w, ksh_w, rev_full, rev_w;
  logic [PART_W-1:0] samp_ext;
  cplx_t           bf_x, bf_y;

  assign accept   = in_valid && in_ready;
  assign room     = cnt_r < CNTW'(MAX_POINTS);
  assign cnt_inc  = room ? cnt_r + CNTW'(1) : cnt_r;
  assign samp_ext = PART_W'(in_sample);

  // span halves and index split for the current stage
  assign mid_w = AW'(1) << (sl_r - LGW'(1));
  assign low_w = mid_w - AW'(1);
  assign q_w   = j_r & low_w;
  assign top_w = AW'({j_r & ~low_w, 1'b0}) | q_w;
  assign bot_w = top_w | mid_w;
  assign ksh_w = q_w << (LGW'(AW) - sl_r);
  assign tw_k  = TWAW'(ksh_w);

  // bit-reversed pointer over lg bits
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      rev_full[i] = ptr_r[AW-1-i];
    end
  end
  assign rev_w = rev_full >> (LGW'(AW) - lg_r);

  fpd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .phase (32'(k_r) << (32 - AW)),
    .done  (cordic_done),
    .tw    (cordic_tw)
  );

  fpd_butterfly u_bf (
    .clk (clk),
    .a   (rd_a_r),
    .b   (rd_b_r),
    .w   (tw_rd_r),
    .x   (bf_x),
    .y   (bf_y)
  );

  fpd_mag u_mag (
    .clk (clk),
    .d   (rd_a_r),
    .mag (mag)
  );

  // memory port control
  always_comb begin
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    rd_en        = 1'b0;
    ra           = ptr_r[AW-1:0];
    rb           = rev_w;
    tw_we        = 1'b0;
    tw_re        = 1'b0;
    cordic_start = 1'b0;
    unique case (state_r)
      S_TWSTART: cordic_start = 1'b1;
      S_TWWAIT:  tw_we = cordic_done;
      S_LOAD: begin
        we       = accept && room;
        waddr    = cnt_r[AW-1:0];
        wdata.re = samp_ext;
        wdata.im = '0;
      end
      S_PAD: begin
        we    = ptr_r < size_r;
        waddr = ptr_r[AW-1:0];
      end
      S_PERM: rd_en = (ptr_r != size_r) && (CNTW'(rev_w) > ptr_r);
      S_PSW1: begin
        we    = 1'b1;
        waddr = ptr_r[AW-1:0];
        wdata = rd_b_r;
      end
      S_PSW2: begin
        we    = 1'b1;
        waddr = rev_w;
        wdata = rd_a_r;
      end
      S_BFRD: begin
        rd_en = 1'b1;
        tw_re = 1'b1;
        ra    = top_w;
        rb    = bot_w;
      end
      S_BFWT: begin
        we    = 1'b1;
        waddr = top_w;
        wdata = bf_x;
      end
      S_BFWB: begin
        we    = 1'b1;
        waddr = bot_w;
        wdata = bf_y;
      end
      S_SCRD: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (tw_we) begin
      twm[k_r] <= cordic_tw;
    end
    if (tw_re) begin
      tw_rd_r <= twm[tw_k];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_TWSTART: state_nxt = S_TWWAIT;
      S_TWWAIT: begin
        if (cordic_done) begin
          state_nxt = (k_r == TWAW'(TWD - 1)) ? S_LOAD : S_TWSTART;
        end
      end
      S_LOAD: if (accept && in_last_sample) state_nxt = S_PAD;
      S_PAD: begin
        if (ptr_r >= size_r) begin
          state_nxt = (lg_r == '0) ? S_SCRD : S_PERM;
        end
      end
      S_PERM: begin
        if (ptr_r == size_r) begin
          state_nxt = S_BFRD;
        end else if (CNTW'(rev_w) > ptr_r) begin
          state_nxt = S_PSW1;
        end
      end
      S_PSW1:   state_nxt = S_PSW2;
      S_PSW2:   state_nxt = S_PERM;
      S_BFRD:   state_nxt = S_BFWAIT;
      S_BFWAIT: if (wcnt_r == 2'd2) state_nxt = S_BFWT;
      S_BFWT:   state_nxt = S_BFWB;
      S_BFWB: begin
        if (j_r == AW'((size_r >> 1) - CNTW'(1)) && sl_r == lg_r) begin
          state_nxt = S_SCRD;
        end else begin
          state_nxt = S_BFRD;
        end
      end
      S_SCRD:   state_nxt = S_SCWAIT;
      S_SCWAIT: if (wcnt_r == 2'd1) state_nxt = S_SCCMP;
      S_SCCMP:  state_nxt = (ptr_r == (size_r >> 1)) ? S_FREQ : S_SCRD;
      S_FREQ:   state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r) state_nxt = S_LOAD;
      default:  state_nxt = S_TWSTART;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_TWSTART;
      rate_r      <= RATE_RESET;
      cnt_r       <= '0;
      size_r      <= CNTW'(1);
      lg_r        <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        rate_r <= cfg_sample_rate_hz;
      end
      // drop the result once the consumer takes it
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_TWWAIT: if (cordic_done) k_r <= k_r + TWAW'(1);
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt_r <= cnt_inc;
              if (cnt_inc > size_r) begin
                size_r <= size_r << 1;
                lg_r   <= lg_r + LGW'(1);
              end
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            cnt_r       <= '0;
            size_r      <= CNTW'(1);
            lg_r        <= '0;
            ovf_r       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // loop counters and scan datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: if (accept) ptr_r <= cnt_inc;
      S_PAD: begin
        if (ptr_r < size_r) begin
          ptr_r <= ptr_r + CNTW'(1);
        end else begin
          ptr_r  <= '0;
          best_r <= '0;
          bmag_r <= '0;
        end
      end
      S_PERM: begin
        if (ptr_r == size_r) begin
          sl_r <= LGW'(1);
          j_r  <= '0;
        end else if (CNTW'(rev_w) <= ptr_r) begin
          ptr_r <= ptr_r + CNTW'(1);
        end
      end
      S_PSW2:   ptr_r <= ptr_r + CNTW'(1);
      S_BFRD:   wcnt_r <= '0;
      S_BFWAIT: wcnt_r <= wcnt_r + 2'd1;
      S_BFWB: begin
        if (j_r == AW'((size_r >> 1) - CNTW'(1))) begin
          j_r    <= '0;
          sl_r   <= sl_r + LGW'(1);
          ptr_r  <= '0;
          best_r <= '0;
          bmag_r <= '0;
        end else begin
          j_r <= j_r + AW'(1);
        end
      end
      S_SCRD:   wcnt_r <= '0;
      S_SCWAIT: wcnt_r <= wcnt_r + 2'd1;
      S_SCCMP: begin
        // strict compare keeps the first bin of equal magnitude
        if (mag > bmag_r) begin
          bmag_r <= mag;
          best_r <= ptr_r[AW-1:0];
        end
        ptr_r <= ptr_r + CNTW'(1);
      end
      S_FREQ: prod_r <= PRODW'(best_r) * PRODW'(rate_r);
      S_DONE: begin
        if (!out_valid_r) begin
          out_peak_r  <= PEAK_W'(best_r);
          out_freq_r  <= FREQ_W'(prod_r >> lg_r);
          out_size_r  <= SIZE_W'(size_r);
          out_trunc_r <= ovf_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready         = (state_r == S_LOAD);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_peak_bin     = out_peak_r;
  assign out_frequency_hz = out_freq_r;
  assign out_fft_size     = out_size_r;
  assign out_truncated    = out_trunc_r;

  // a final sample closes the block: no further transaction until the result is built
  `ASSERT_NXT(a_last_closes, clk, rst_n, in_valid && in_ready && in_last_sample, !in_ready)
  // while loading, the transform size always covers the stored samples
  `ASSERT_IMP(a_size_covers, clk, rst_n, state_r == S_LOAD, (cnt_r <= size_r) && room | (cnt_r == CNTW'(MAX_POINTS)))
  // a result appears only out of the finishing state
  `ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DONE)
  // butterfly write-back stays inside the current transform
  `ASSERT_IMP(a_bf_in_range, clk, rst_n, state_r == S_BFWT || state_r == S_BFWB, CNTW'(waddr) < size_r)

endmodule

>>> dv/tb_fft_peak_frequency_detector_top.sv
// Self-checking testbench for the FFT peak-frequency detector: directed and random blocks against a predictor
module tb_fft_peak_frequency_detector_top;
  import fpd_pkg::*;

  localparam int MAX_PTS      = 1024;
  localparam int SAMPLE_W     = 16;
  localparam int WATCHDOG_MAX = 300000;
  localparam int SETTLE       = 400;
  localparam int REPORT_MAX   = 10;

  // kinds of block content
  typedef enum int {
    CONTENT_NOISE, CONTENT_QUIET, CONTENT_SQUARE, CONTENT_EXTREME, CONTENT_SPIKE
  } content_e;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct {
    logic [PEAK_W-1:0] peak_bin;
    logic [FREQ_W-1:0] freq_hz;
    logic [SIZE_W-1:0] fft_size;
    logic              truncated;
  } peak_result_t;

  // CORDIC arctangent steps in units of 2^-32 turn
  localparam longint ATAN_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_last_sample = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [PEAK_W-1:0]          out_peak_bin;
  logic [FREQ_W-1:0]          out_frequency_hz;
  logic [SIZE_W-1:0]          out_fft_size;
  logic                       out_truncated;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [RATE_W-1:0]          cfg_sample_rate_hz = '0;

  fft_peak_frequency_detector_top #(
    .MAX_POINTS (MAX_PTS),
    .SAMPLE_BITS(SAMPLE_W)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_peak_bin      (out_peak_bin),
    .out_frequency_hz  (out_frequency_hz),
    .out_fft_size      (out_fft_size),
    .out_truncated     (out_truncated),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sample_rate_hz(cfg_sample_rate_hz)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectation stores
  sample_item_t pending_samples[$];
  peak_result_t expected_peaks[$];
  sample_item_t cur_item;

  // Idling knobs, set per phase by the sequencer
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;

  // Bookkeeping
  int  mismatches     = 0;
  int  samples_taken  = 0;
  int  peaks_checked  = 0;
  int  rate_writes    = 0;
  int  idle_cycles    = 0;
  logic tx_holding;

  // Predictor state: sample store, fill level, drop flag and rate register
  longint    spec_re [2*MAX_PTS];
  longint    spec_im [2*MAX_PTS];
  int        fill_count;
  bit        dropped_any;
  longint    rate_hz;

  function automatic longint sat_part(longint v);
    if (v > 64'sd67108863) return 64'sd67108863;
    if (v < -64'sd67108864) return -64'sd67108864;
    return v;
  endfunction

  function automatic longint round_q17(longint v);
    longint r;
    r = (v + 4096) >>> 13;
    if (r < 0) r = 0;
    if (r > 131072) r = 131072;
    return r;
  endfunction

  // W = cos - j*sin of the angle given as a 32-bit fraction of a turn
  task automatic twiddle_of(input logic [31:0] phase, output longint wr, output longint wi);
    longint cx, cy, z, dx, dy, c, s, cf, sf;
    cx = 652032874;
    cy = 0;
    z  = longint'(phase[29:0]);
    for (int st = 0; st < 30; st++) begin
      dx = cy >>> st;
      dy = cx >>> st;
      if (z >= 0) begin
        cx = cx - dx; cy = cy + dy; z = z - ATAN_STEP[st];
      end else begin
        cx = cx + dx; cy = cy - dy; z = z + ATAN_STEP[st];
      end
    end
    c = round_q17(cx);
    s = round_q17(cy);
    case (phase[31:30])
      2'd0: begin cf = c;  sf = s;  end
      2'd1: begin cf = -s; sf = c;  end
      2'd2: begin cf = -c; sf = -s; end
      default: begin cf = s; sf = -c; end
    endcase
    wr = cf;
    wi = -sf;
  endtask

  // In-place decimation-in-time transform with saturating butterflies
  task automatic run_fft(input int size, input int lg);
    int     rev, src, mid, span, top_i, bot_i;
    longint wr, wi, pr, pi, ur, ui, tmp;
    for (int p = 0; p < size; p++) begin
      rev = 0;
      src = p;
      for (int b = 0; b < lg; b++) begin
        rev = (rev << 1) | (src & 1);
        src = src >> 1;
      end
      if (rev > p) begin
        tmp = spec_re[p]; spec_re[p] = spec_re[rev]; spec_re[rev] = tmp;
        tmp = spec_im[p]; spec_im[p] = spec_im[rev]; spec_im[rev] = tmp;
      end
    end
    for (int sl = 1; sl <= lg; sl++) begin
      span = 1 << sl;
      mid  = span >> 1;
      for (int q = 0; q < mid; q++) begin
        twiddle_of(32'(longint'(q) << (32 - sl)), wr, wi);
        for (int base = 0; base < size; base += span) begin
          top_i = base + q;
          bot_i = base + q + mid;
          pr = (wr * spec_re[bot_i] - wi * spec_im[bot_i] + 65536) >>> 17;
          pi = (wr * spec_im[bot_i] + wi * spec_re[bot_i] + 65536) >>> 17;
          ur = spec_re[top_i];
          ui = spec_im[top_i];
          spec_re[top_i] = sat_part(ur + pr);
          spec_im[top_i] = sat_part(ui + pi);
          spec_re[bot_i] = sat_part(ur - pr);
          spec_im[bot_i] = sat_part(ui - pi);
        end
      end
    end
  endtask

  // Take one accepted sample; on a block end, transform and queue the peak
  task automatic absorb_sample(input sample_item_t it);
    int           size, lg, best;
    longint       mag, best_mag;
    peak_result_t res;
    if (fill_count < MAX_PTS) begin
      spec_re[fill_count] = longint'(it.sample);
      spec_im[fill_count] = 0;
      fill_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!it.last) return;
    size = 1;
    lg   = 0;
    while (size < fill_count) begin
      size = size << 1;
      lg++;
    end
    for (int p = fill_count; p < size; p++) begin
      spec_re[p] = 0;
      spec_im[p] = 0;
    end
    run_fft(size, lg);
    best     = 0;
    best_mag = 0;
    for (int p = 0; p <= size / 2; p++) begin
      mag = spec_re[p] * spec_re[p] + spec_im[p] * spec_im[p];
      if (mag > best_mag) begin
        best_mag = mag;
        best     = p;
      end
    end
    res.peak_bin  = PEAK_W'(best);
    res.freq_hz   = FREQ_W'((longint'(best) * rate_hz) / size);
    res.fft_size  = SIZE_W'(size);
    res.truncated = dropped_any;
    expected_peaks.push_back(res);
    fill_count  = 0;
    dropped_any = 1'b0;
  endtask

  // Driver: hold the transaction until accepted, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_holding = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        absorb_sample(cur_item);
        samples_taken++;
      end
      if (!tx_holding) begin
        if (pending_samples.size() > 0 && int'($urandom_range(99)) >= tx_idle_pct) begin
          cur_item       = pending_samples.pop_front();
          in_valid       <= 1'b1;
          in_sample      <= cur_item.sample;
          in_last_sample <= cur_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_peaks.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("ERROR: unexpected result bin=%0d freq=%0d size=%0d trunc=%0b",
                     out_peak_bin, out_frequency_hz, out_fft_size, out_truncated);
        end else begin
          peak_result_t exp_r;
          exp_r = expected_peaks.pop_front();
          peaks_checked++;
          if (out_peak_bin !== exp_r.peak_bin || out_frequency_hz !== exp_r.freq_hz ||
              out_fft_size !== exp_r.fft_size || out_truncated !== exp_r.truncated) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("ERROR: result %0d exp bin=%0d freq=%0d size=%0d trunc=%0b, got bin=%0d freq=%0d size=%0d trunc=%0b",
                       peaks_checked, exp_r.peak_bin, exp_r.freq_hz, exp_r.fft_size,
                       exp_r.truncated, out_peak_bin, out_frequency_hz, out_fft_size,
                       out_truncated);
          end
        end
      end
      // a long hold-off lets the block fill up and push back on its input
      if (rx_hold > 0) begin
        rx_hold   <= rx_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= int'($urandom_range(99)) >= rx_stall_pct;
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("TIMEOUT: no progress for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Write the rate register through its handshake and track it in the predictor
  task automatic write_rate(input logic [RATE_W-1:0] value);
    @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_sample_rate_hz <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_hz = longint'(value);
    rate_writes++;
  endtask

  // Queue one block of samples; the last one carries the end marker
  task automatic queue_block(input int len, input content_e kind);
    sample_item_t it;
    int           amp, period;
    amp    = $urandom_range(1, 32767);
    period = $urandom_range(2, 16);
    for (int i = 0; i < len; i++) begin
      case (kind)
        CONTENT_NOISE:   it.sample = SAMPLE_W'($urandom_range(0, 65535));
        CONTENT_QUIET:   it.sample = SAMPLE_W'(int'($urandom_range(0, 127)) - 64);
        CONTENT_SQUARE:  it.sample = ((i % period) < period / 2) ? SAMPLE_W'(amp)
                                                                 : SAMPLE_W'(-amp);
        CONTENT_EXTREME: it.sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        default:         it.sample = (i == len / 2) ? SAMPLE_W'(amp) : '0;
      endcase
      it.last = (i == len - 1);
      pending_samples.push_back(it);
    end
  endtask

  task automatic queue_fixed(input logic signed [SAMPLE_W-1:0] v, input logic last);
    sample_item_t it;
    it.sample = v;
    it.last   = last;
    pending_samples.push_back(it);
  endtask

  // Queue random blocks, mostly short, until about n samples are waiting
  task automatic queue_random(input int n);
    int target, len;
    target = pending_samples.size() + n;
    while (pending_samples.size() < target) begin
      len = ($urandom_range(9) < 7) ? $urandom_range(1, 16) : $urandom_range(17, 70);
      queue_block(len, content_e'($urandom_range(0, 4)));
    end
  endtask

  // Wait until every queued sample is sent and every expected result has come, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() > 0 || expected_peaks.size() > 0 || in_valid);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  initial begin
    fill_count  = 0;
    dropped_any = 1'b0;
    rate_hz     = 48000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single sample, silent block, extremes, padding, two samples
    set_idling(0, 0);
    queue_fixed(16'sh7FFF, 1'b1);
    for (int i = 0; i < 4; i++) queue_fixed('0, i == 3);
    for (int i = 0; i < 8; i++) queue_fixed((i % 2) ? 16'sh8000 : 16'sh7FFF, i == 7);
    for (int i = 0; i < 3; i++) queue_fixed(16'sh8000, i == 2);
    queue_fixed(16'sd1, 1'b0);
    queue_fixed(-16'sd1, 1'b1);
    drain();

    // Lowest rate, no idling
    write_rate(24'd1);
    queue_random(90);
    drain();

    // Highest rate, sender mostly idle
    write_rate(24'hFFFFFF);
    set_idling(87, 0);
    queue_random(90);
    drain();

    // Zero rate, receiver mostly stalling
    write_rate('0);
    set_idling(0, 87);
    queue_random(90);
    drain();

    // Random rate, both sides idling, with one long receiver hold-off
    write_rate(RATE_W'($urandom_range(1, 24'hFFFFFF)));
    set_idling(33, 33);
    rx_hold = 3000;
    set_idling(0, 33);
    queue_random(40);
    drain();
    set_idling(33, 33);
    queue_random(90);
    drain();

    // Larger size: one long block padded up to 256 points
    write_rate(24'd44100);
    set_idling(0, 0);
    queue_block(129, CONTENT_SQUARE);
    drain();

    if (expected_peaks.size() != 0) begin
      mismatches += expected_peaks.size();
      $display("ERROR: %0d expected results never arrived", expected_peaks.size());
    end
    $display("Covered %0d samples and %0d checked peaks over %0d rate settings,",
             samples_taken, peaks_checked, rate_writes + 1);
    $display("with idle and stall mixes, a long output hold-off and a long padded block.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
